>>> rtl/brit_pkg.sv
// Shared types and codes for the binary run interval tracker.
// No dependencies; the cell, row, top level and testbench import this package.
`default_nettype none

package brit_pkg;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PREV_ZERO = 2'd0,
        PREV_ONE  = 2'd1,
        PREV_NONE = 2'd2
    } prev_t;

    localparam logic [1:0] KIND_OPEN   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // query token walking the cell row
    typedef struct packed {
        logic valid;
        logic hit;
    } token_t;

endpackage

`default_nettype wire

>>> rtl/brit_in_if.sv
// Input channel of the run interval tracker: valid/ready plus item payload.
// No dependencies.
`default_nettype none

interface brit_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic               sample_bit;
    logic signed [31:0] query_first;
    logic signed [31:0] query_last;

    modport source (output valid, output action, output sample_bit,
                    output query_first, output query_last, input ready);
    modport sink   (input valid, input action, input sample_bit,
                    input query_first, input query_last, output ready);
endinterface

`default_nettype wire

>>> rtl/brit_out_if.sv
// Result channel of the run interval tracker: valid/ready plus result payload.
// No dependencies.
`default_nettype none

interface brit_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic signed [31:0] run_first;
    logic signed [31:0] run_last;
    logic               contained;
    logic               table_full;

    modport source (output valid, output result_kind, output run_first,
                    output run_last, output contained, output table_full,
                    input ready);
    modport sink   (input valid, input result_kind, input run_first,
                    input run_last, input contained, input table_full,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/brit_cell.sv
// One cell of the interval row: holds one stored interval, shifts it to the
// next cell on a store, and folds its containment test into the query token.
// Depends on brit_pkg.
`default_nettype none

module brit_cell #(
    parameter int POSITION_BITS = 32,
    parameter int CMP_W         = 32,
    parameter int CNT_W         = 9,
    parameter int IDX           = 0
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            shift_en,
    input  wire logic signed [POSITION_BITS-1:0] first_in,
    input  wire logic signed [POSITION_BITS-1:0] last_in,
    input  wire brit_pkg::token_t          tok_in,
    input  wire logic signed [CMP_W-1:0]   qf,
    input  wire logic signed [CMP_W-1:0]   ql,
    input  wire logic [CNT_W-1:0]          count,
    output logic signed [POSITION_BITS-1:0] first_out,
    output logic signed [POSITION_BITS-1:0] last_out,
    output brit_pkg::token_t               tok_out
);
    import brit_pkg::*;

    logic signed [POSITION_BITS-1:0] first_reg;
    logic signed [POSITION_BITS-1:0] last_reg;
    token_t                          tok_reg;
    token_t                          tok_next;
    logic signed [CMP_W-1:0]         first_ext;
    logic signed [CMP_W-1:0]         last_ext;
    logic                            occupied;

    // entries shift in at cell 0, so cell IDX is live while IDX < count
    assign occupied  = (CNT_W'(IDX) < count);
    assign first_ext = CMP_W'(first_reg);
    assign last_ext  = CMP_W'(last_reg);

    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.hit   = tok_in.hit |
                         (tok_in.valid & occupied & (first_ext <= qf) & (last_ext >= ql));
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            first_reg <= first_in;
            last_reg  <= last_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign first_out = first_reg;
    assign last_out  = last_reg;
    assign tok_out   = tok_reg;

endmodule

`default_nettype wire

>>> rtl/brit_row.sv
// Row of interval cells: stored intervals shift along it on each store and a
// query token walks it one cell per cycle. Depends on brit_pkg, brit_cell.
`default_nettype none

module brit_row #(
    parameter int MAX_INTERVALS = 256,
    parameter int POSITION_BITS = 32,
    parameter int CMP_W         = 32,
    parameter int CNT_W         = 9
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            shift_en,
    input  wire logic signed [POSITION_BITS-1:0] new_first,
    input  wire logic signed [POSITION_BITS-1:0] new_last,
    input  wire brit_pkg::token_t          launch,
    input  wire logic signed [CMP_W-1:0]   qf,
    input  wire logic signed [CMP_W-1:0]   ql,
    input  wire logic [CNT_W-1:0]          count,
    output brit_pkg::token_t               tok_out
);
    import brit_pkg::*;

    logic signed [POSITION_BITS-1:0] first_chain [MAX_INTERVALS+1];
    logic signed [POSITION_BITS-1:0] last_chain  [MAX_INTERVALS+1];
    token_t                          tok_chain   [MAX_INTERVALS+1];

    assign first_chain[0] = new_first;
    assign last_chain[0]  = new_last;
    assign tok_chain[0]   = launch;

    for (genvar i = 0; i < MAX_INTERVALS; i++)
    begin : g_cell
        brit_cell #(
            .POSITION_BITS (POSITION_BITS),
            .CMP_W         (CMP_W),
            .CNT_W         (CNT_W),
            .IDX           (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (shift_en),
            .first_in  (first_chain[i]),
            .last_in   (last_chain[i]),
            .tok_in    (tok_chain[i]),
            .qf        (qf),
            .ql        (ql),
            .count     (count),
            .first_out (first_chain[i+1]),
            .last_out  (last_chain[i+1]),
            .tok_out   (tok_chain[i+1])
        );
    end

    assign tok_out = tok_chain[MAX_INTERVALS];

endmodule

`default_nettype wire

>>> rtl/binary_run_interval_tracker.sv
// Binary run interval tracker, top level. Depends on brit_pkg, brit_in_if,
// brit_out_if, brit_row.
// Sample, finish and clear beats: one per cycle while the result side is not
// stalled, any result registered in the cycle after. Query beats: the answer waits
// for the token to walk the row one cell per cycle; no beat is taken meanwhile.
// Reset (rst_n low, async) clears counters, flags and handshake state; table
// entries stay undefined and need no clearing pass.
`default_nettype none

module binary_run_interval_tracker #(
    parameter int MAX_INTERVALS = 256,
    parameter int POSITION_BITS = 32
) (
    input  wire        clk,
    input  wire        rst_n,
    brit_in_if.sink    items,
    brit_out_if.source results
);
    import brit_pkg::*;

    localparam int CMP_W = (POSITION_BITS > 32) ? POSITION_BITS : 32;
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] POS_NONE = '1;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_QUERY = 2'b10
    } state_t;

    state_t                          state_reg, state_next;
    prev_t                           prev_reg, prev_next;
    logic signed [POSITION_BITS-1:0] pos_reg, pos_next;
    logic signed [POSITION_BITS-1:0] open_start_reg, open_start_next;
    logic signed [POSITION_BITS-1:0] closed_end_reg, closed_end_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            ovf_reg, ovf_next;
    logic signed [CMP_W-1:0]         qf_reg, qf_next;
    logic signed [CMP_W-1:0]         ql_reg, ql_next;
    token_t                          launch_reg, launch_next;

    logic                            out_valid_reg, out_valid_next;
    logic [1:0]                      out_kind_reg, out_kind_next;
    logic [31:0]                     out_first_reg, out_first_next;
    logic [31:0]                     out_last_reg, out_last_next;
    logic                            out_hit_reg, out_hit_next;
    logic                            out_full_reg, out_full_next;
    logic                            load;

    logic signed [POSITION_BITS-1:0] pos_inc;
    logic                            accept;
    logic                            shift_en;
    token_t                          tok_out;

    function automatic logic [31:0] to_out(input logic signed [POSITION_BITS-1:0] v);
        logic signed [CMP_W-1:0] e;
        e = CMP_W'(v);
        return e[31:0];
    endfunction

    assign pos_inc      = (pos_reg != POS_MAX) ? (pos_reg + POSITION_BITS'(1)) : pos_reg;
    assign items.ready  = (state_reg == ST_IDLE) && (!out_valid_reg || results.ready);
    assign accept       = items.valid && items.ready;

    always_comb
    begin
        state_next      = state_reg;
        prev_next       = prev_reg;
        pos_next        = pos_reg;
        open_start_next = open_start_reg;
        closed_end_next = closed_end_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        qf_next         = qf_reg;
        ql_next         = ql_reg;
        launch_next     = '0;
        shift_en        = 1'b0;
        load            = 1'b0;
        out_kind_next   = out_kind_reg;
        out_first_next  = out_first_reg;
        out_last_next   = out_last_reg;
        out_hit_next    = out_hit_reg;
        out_full_next   = out_full_reg;

        if ((state_reg == ST_QUERY) && tok_out.valid)
        begin
            load           = 1'b1;
            out_kind_next  = KIND_QUERY;
            out_first_next = '0;
            out_last_next  = '0;
            out_hit_next   = tok_out.hit;
            out_full_next  = ovf_reg;
            state_next     = ST_IDLE;
        end

        if (accept)
        begin
            case (action_t'(items.action))
                ACT_SAMPLE:
                begin
                    pos_next  = pos_inc;
                    prev_next = items.sample_bit ? PREV_ONE : PREV_ZERO;
                    if ((prev_reg == PREV_ZERO) && items.sample_bit)
                    begin
                        open_start_next = pos_inc;
                        load            = 1'b1;
                        out_kind_next   = KIND_CLOSED;
                        out_first_next  = to_out(closed_end_reg);
                        out_last_next   = to_out(pos_inc);
                        out_hit_next    = 1'b0;
                        out_full_next   = ovf_reg;
                    end
                    else if ((prev_reg == PREV_ONE) && !items.sample_bit)
                    begin
                        closed_end_next = pos_inc;
                        if (count_reg < CNT_W'(MAX_INTERVALS))
                        begin
                            shift_en   = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        load           = 1'b1;
                        out_kind_next  = KIND_OPEN;
                        out_first_next = to_out(open_start_reg);
                        out_last_next  = to_out(pos_inc);
                        out_hit_next   = 1'b0;
                        out_full_next  = (count_reg < CNT_W'(MAX_INTERVALS)) ? ovf_reg : 1'b1;
                    end
                end
                ACT_QUERY:
                begin
                    qf_next           = CMP_W'(items.query_first);
                    ql_next           = CMP_W'(items.query_last);
                    launch_next.valid = 1'b1;
                    launch_next.hit   = 1'b0;
                    state_next        = ST_QUERY;
                end
                ACT_FINISH:
                begin
                    case (prev_reg)
                        PREV_ZERO:
                        begin
                            load           = 1'b1;
                            out_kind_next  = KIND_CLOSED;
                            out_first_next = to_out(closed_end_reg);
                            out_last_next  = to_out(pos_reg);
                            out_hit_next   = 1'b0;
                            out_full_next  = ovf_reg;
                        end
                        PREV_ONE:
                        begin
                            // trailing open run keeps its true kind, not stored
                            load           = 1'b1;
                            out_kind_next  = KIND_OPEN;
                            out_first_next = to_out(open_start_reg);
                            out_last_next  = to_out(pos_reg);
                            out_hit_next   = 1'b0;
                            out_full_next  = ovf_reg;
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    prev_next       = PREV_NONE;
                    pos_next        = POS_NONE;
                    open_start_next = POS_NONE;
                    closed_end_next = POS_NONE;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                end
            endcase
        end

        out_valid_next = (out_valid_reg && !results.ready) || load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_reg       <= PREV_NONE;
            pos_reg        <= POS_NONE;
            open_start_reg <= POS_NONE;
            closed_end_reg <= POS_NONE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            launch_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_reg       <= prev_next;
            pos_reg        <= pos_next;
            open_start_reg <= open_start_next;
            closed_end_reg <= closed_end_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            launch_reg     <= launch_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qf_reg        <= qf_next;
        ql_reg        <= ql_next;
        out_kind_reg  <= out_kind_next;
        out_first_reg <= out_first_next;
        out_last_reg  <= out_last_next;
        out_hit_reg   <= out_hit_next;
        out_full_reg  <= out_full_next;
    end

    brit_row #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .POSITION_BITS (POSITION_BITS),
        .CMP_W         (CMP_W),
        .CNT_W         (CNT_W)
    ) u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (shift_en),
        .new_first (open_start_reg),
        .new_last  (pos_inc),
        .launch    (launch_reg),
        .qf        (qf_reg),
        .ql        (ql_reg),
        .count     (count_reg),
        .tok_out   (tok_out)
    );

    assign results.valid       = out_valid_reg;
    assign results.result_kind = out_kind_reg;
    assign results.run_first   = out_first_reg;
    assign results.run_last    = out_last_reg;
    assign results.contained   = out_hit_reg;
    assign results.table_full  = out_full_reg;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for binary_run_interval_tracker: run reports, table fill
// and overflow, containment queries, finish and clear, under random idling on both sides.
// Depends on brit_pkg, brit_in_if, brit_out_if and the RTL of the tracker.

module tb_top;

    import brit_pkg::*;

    localparam int     TABLE_DEPTH = 256;
    localparam longint POS_LIMIT   = (longint'(1) << 31) - 1;
    localparam int     MAX_GAP     = 18;
    localparam int     ITEM_TOTAL  = 1350;

    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] first;
        logic signed [31:0] last;
        logic               contained;
        logic               full;
    } run_report_t;

    // Tracks runs and the interval table, queues the reports the block owes.
    class run_scoreboard;
        prev_t       last_bit;
        longint      pos;
        longint      open_start;
        longint      closed_end;
        longint      span_first [TABLE_DEPTH];
        longint      span_last [TABLE_DEPTH];
        int          span_count;
        bit          dropped;
        run_report_t awaited [$];
        int          errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            last_bit   = PREV_NONE;
            pos        = -1;
            open_start = -1;
            closed_end = -1;
            span_count = 0;
            dropped    = 1'b0;
        endfunction

        function void push_report(logic [1:0] kind, longint first, longint last, bit hit);
            run_report_t r;
            r.kind      = kind;
            r.first     = first[31:0];
            r.last      = last[31:0];
            r.contained = hit;
            r.full      = dropped;
            awaited.insert(awaited.size(), r);
        endfunction

        function void note_item(action_t act, bit b, logic signed [31:0] qf,
                                logic signed [31:0] ql);
            bit hit;
            case (act)
                ACT_SAMPLE:
                begin
                    if (pos < POS_LIMIT)
                        pos++;
                    if (last_bit == PREV_ZERO && b)
                    begin
                        open_start = pos;
                        push_report(KIND_CLOSED, closed_end, pos, 1'b0);
                    end
                    else if (last_bit == PREV_ONE && !b)
                    begin
                        closed_end = pos;
                        if (span_count < TABLE_DEPTH)
                        begin
                            span_first[span_count] = open_start;
                            span_last[span_count]  = pos;
                            span_count++;
                        end
                        else
                            dropped = 1'b1;
                        push_report(KIND_OPEN, open_start, pos, 1'b0);
                    end
                    last_bit = b ? PREV_ONE : PREV_ZERO;
                end
                ACT_QUERY:
                begin
                    hit = 1'b0;
                    for (int i = 0; i < span_count; i++)
                        if (span_first[i] <= longint'(qf) && span_last[i] >= longint'(ql))
                            hit = 1'b1;
                    push_report(KIND_QUERY, 0, 0, hit);
                end
                ACT_FINISH:
                begin
                    // trailing run is reported with its true kind, never stored
                    if (last_bit == PREV_ZERO)
                        push_report(KIND_CLOSED, closed_end, pos, 1'b0);
                    else if (last_bit == PREV_ONE)
                        push_report(KIND_OPEN, open_start, pos, 1'b0);
                end
                default:
                    clear_state();
            endcase
        endfunction

        function void check_result(run_report_t got);
            run_report_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat kind=%0d first=%0d last=%0d",
                         $time, got.kind, got.first, got.last);
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind)
            begin
                errors++;
                $display("%0t: result_kind expected %0d actual %0d",
                         $time, want.kind, got.kind);
            end
            if (got.first !== want.first)
            begin
                errors++;
                $display("%0t: run_first expected %0d actual %0d",
                         $time, want.first, got.first);
            end
            if (got.last !== want.last)
            begin
                errors++;
                $display("%0t: run_last expected %0d actual %0d",
                         $time, want.last, got.last);
            end
            if (got.contained !== want.contained)
            begin
                errors++;
                $display("%0t: contained expected %0b actual %0b",
                         $time, want.contained, got.contained);
            end
            if (got.full !== want.full)
            begin
                errors++;
                $display("%0t: table_full expected %0b actual %0b",
                         $time, want.full, got.full);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    brit_in_if  items_if ();
    brit_out_if results_if ();

    run_scoreboard sb = new();
    bit quiet_send = 1'b0;
    bit quiet_recv = 1'b0;
    int items_sent = 0;

    binary_run_interval_tracker #(
        .MAX_INTERVALS (TABLE_DEPTH),
        .POSITION_BITS (32)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_beat(action_t act, bit b, logic signed [31:0] qf,
                             logic signed [31:0] ql);
        int gap;
        gap = quiet_send ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            items_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_if.valid       <= 1'b1;
        items_if.action      <= act;
        items_if.sample_bit  <= b;
        items_if.query_first <= qf;
        items_if.query_last  <= ql;
        do @(posedge clk); while (!items_if.ready);
        sb.note_item(act, b, qf, ql);
        items_sent++;
        if ($urandom_range(0, 39) == 0)
            quiet_send = !quiet_send;
    endtask

    // hold off the sender until every owed result has been taken
    task automatic drain_results();
        items_if.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic pick_query(output logic signed [31:0] qf, output logic signed [31:0] ql);
        int     mode;
        int     idx;
        longint f;
        longint l;
        longint a;
        longint b;
        logic signed [31:0] corner [3];
        corner[0] = -32'sd1;
        corner[1] = 32'sd0;
        corner[2] = 32'sh7fffffff;
        mode = $urandom_range(0, 9);
        if (sb.span_count == 0 && mode <= 4)
            mode = 5;
        f = 0;
        l = 0;
        if (sb.span_count > 0)
        begin
            idx = $urandom_range(0, sb.span_count - 1);
            f = sb.span_first[idx];
            l = sb.span_last[idx];
        end
        case (mode)
            0, 1:
            begin
                a = f + $urandom_range(0, int'(l - f));
                b = a;
            end
            2, 3:
            begin
                a = f + $urandom_range(0, int'(l - f));
                b = a + $urandom_range(0, int'(l - a));
            end
            4:
            begin
                // just past one end of a stored interval
                if (f >= 0 && $urandom_range(0, 1) == 1)
                begin
                    a = f - 1;
                    b = l;
                end
                else
                begin
                    a = f;
                    b = l + 1;
                end
            end
            5, 6:
            begin
                a = longint'($urandom_range(0, int'(sb.pos) + 4)) - 1;
                b = longint'($urandom_range(0, int'(sb.pos) + 4)) - 1;
            end
            7:
            begin
                a = longint'($urandom() & 32'h7fffffff);
                b = longint'($urandom() & 32'h7fffffff);
            end
            8:
            begin
                a = longint'(corner[$urandom_range(0, 2)]);
                b = longint'(corner[$urandom_range(0, 2)]);
            end
            default:
            begin
                a = longint'($urandom_range(0, int'(sb.pos) + 4)) - 1;
                b = a;
            end
        endcase
        qf = a[31:0];
        ql = b[31:0];
    endtask

    task automatic random_item(int pct_clear, int pct_finish, int pct_query, int toggle_pct);
        int r;
        bit b;
        logic signed [31:0] qf;
        logic signed [31:0] ql;
        r  = $urandom_range(0, 99);
        qf = $urandom();
        ql = $urandom();
        b  = 1'($urandom_range(0, 1));
        if (r < pct_clear)
            send_beat(ACT_CLEAR, b, qf, ql);
        else if (r < pct_clear + pct_finish)
            send_beat(ACT_FINISH, b, qf, ql);
        else if (r < pct_clear + pct_finish + pct_query)
        begin
            pick_query(qf, ql);
            send_beat(ACT_QUERY, b, qf, ql);
        end
        else
        begin
            if (sb.last_bit != PREV_NONE)
            begin
                if ($urandom_range(0, 99) < toggle_pct)
                    b = (sb.last_bit == PREV_ZERO);
                else
                    b = (sb.last_bit == PREV_ONE);
            end
            send_beat(ACT_SAMPLE, b, qf, ql);
        end
    endtask

    initial
    begin : stimulus
        int after_full;
        int toggle_pct;
        rst_n                <= 1'b0;
        items_if.valid       <= 1'b0;
        items_if.action      <= ACT_SAMPLE;
        items_if.sample_bit  <= 1'b0;
        items_if.query_first <= 32'sd0;
        items_if.query_last  <= 32'sd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // finish before any sample, query of an empty table
        send_beat(ACT_FINISH, 1'b0, 32'sd0, 32'sd0);
        send_beat(ACT_QUERY,  1'b0, 32'sd0, 32'sd0);
        // open run from stream start, repeated bits, repeated finish
        send_beat(ACT_SAMPLE, 1'b1, 32'sd0, 32'sd0);
        send_beat(ACT_SAMPLE, 1'b1, 32'sd0, 32'sd0);
        send_beat(ACT_SAMPLE, 1'b0, 32'sd0, 32'sd0);
        send_beat(ACT_SAMPLE, 1'b0, 32'sd0, 32'sd0);
        send_beat(ACT_FINISH, 1'b0, 32'sd0, 32'sd0);
        send_beat(ACT_FINISH, 1'b1, 32'sd0, 32'sd0);
        send_beat(ACT_SAMPLE, 1'b1, 32'sd0, 32'sd0);
        send_beat(ACT_FINISH, 1'b0, 32'sd0, 32'sd0);
        send_beat(ACT_SAMPLE, 1'b0, 32'sd0, 32'sd0);
        // points, ranges, reversed and extreme bounds
        send_beat(ACT_QUERY, 1'b0, -32'sd1, -32'sd1);
        send_beat(ACT_QUERY, 1'b1, 32'sd0, 32'sd2);
        send_beat(ACT_QUERY, 1'b0, -32'sd1, 32'sd3);
        send_beat(ACT_QUERY, 1'b0, 32'sd4, 32'sd5);
        send_beat(ACT_QUERY, 1'b0, 32'sd3, 32'sd3);
        send_beat(ACT_QUERY, 1'b0, 32'sd5, 32'sd4);
        send_beat(ACT_QUERY, 1'b0, 32'sh7fffffff, 32'sh7fffffff);
        send_beat(ACT_QUERY, 1'b0, -32'sd1, 32'sh7fffffff);
        // clear, then a closed run from stream start
        send_beat(ACT_CLEAR,  1'b1, -32'sd1, -32'sd1);
        send_beat(ACT_QUERY,  1'b0, 32'sd0, 32'sd0);
        send_beat(ACT_FINISH, 1'b0, 32'sd0, 32'sd0);
        send_beat(ACT_SAMPLE, 1'b0, 32'sd0, 32'sd0);
        send_beat(ACT_SAMPLE, 1'b1, 32'sd0, 32'sd0);
        send_beat(ACT_CLEAR,  1'b0, 32'sd0, 32'sd0);
        drain_results();

        // fill the table past its depth without clearing
        after_full = 0;
        while (items_sent < 680 || after_full < 40)
        begin
            random_item(0, 6, 8, 80);
            if (sb.dropped)
                after_full++;
        end
        drain_results();
        repeat (MAX_GAP) @(posedge clk);

        toggle_pct = 30;
        while (items_sent < ITEM_TOTAL)
        begin
            if (items_sent % 50 == 0)
                toggle_pct = $urandom_range(20, 90);
            random_item(3, 10, 12, toggle_pct);
        end
        drain_results();
        // a query answer takes a full walk of the table
        repeat (TABLE_DEPTH + 2 * MAX_GAP) @(posedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin : result_sink
        int          stall;
        run_report_t got;
        results_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet_recv ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            do @(posedge clk); while (!(results_if.valid && results_if.ready));
            got.kind      = results_if.result_kind;
            got.first     = results_if.run_first;
            got.last      = results_if.run_last;
            got.contained = results_if.contained;
            got.full      = results_if.table_full;
            sb.check_result(got);
            if ($urandom_range(0, 39) == 0)
                quiet_recv = !quiet_recv;
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/brit_pkg.sv
rtl/brit_in_if.sv
rtl/brit_out_if.sv
rtl/brit_cell.sv
rtl/brit_row.sv
rtl/binary_run_interval_tracker.sv
verif/tb_top.sv
